@@ rtl/dise_pkg.sv @@
// shared types and constants for the der integer sequence encoder
package dise_pkg;

  localparam int unsigned MaxIntegersDefault = 9;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ElemLenW = 4;
  localparam int unsigned TotalW = 7;

  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagInteger = 8'h02;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [7:0]        tag;
    logic [TotalW-1:0] length;
    logic [ValueW-1:0] content;
    logic              final_res;
  } result_t;

  typedef struct packed {
    logic                done;
    logic [ElemLenW-1:0] len;
  } len_status_t;

  typedef enum logic [1:0] {
    StIdle,
    StLen,
    StHdr,
    StEmit
  } state_e;

endpackage

@@ rtl/dise_len.sv @@
// iterative byte-length unit: one byte shifted off per cycle until the top byte remains
module dise_len (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dise_pkg::ValueW-1:0] value_i,
  output dise_pkg::len_status_t       status_o
);

  logic                          run_q, run_d;
  logic [dise_pkg::ValueW-1:0]   top_q, top_d;
  logic [dise_pkg::ElemLenW-1:0] n_q, n_d;
  logic                          fits;

  assign fits = (top_q[dise_pkg::ValueW-1:8] == '0);

  always_comb begin
    run_d = run_q;
    top_d = top_q;
    n_d   = n_q;
    if (start_i) begin
      run_d = 1'b1;
      top_d = value_i;
      n_d   = dise_pkg::ElemLenW'(1);
    end else if (run_q) begin
      if (fits) begin
        run_d = 1'b0;
      end else begin
        top_d = top_q >> 8;
        n_d   = n_q + dise_pkg::ElemLenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    n_q   <= n_d;
  end

  // pad byte when the most significant byte has its top bit set
  assign status_o.done = run_q && fits;
  assign status_o.len  = n_q + dise_pkg::ElemLenW'(top_q[7]);

endmodule

@@ rtl/dise_store.sv @@
// value and element-length store, one write and one registered read port
module dise_store #(
  parameter int unsigned MaxIntegers = dise_pkg::MaxIntegersDefault,
  parameter int unsigned AddrW = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [dise_pkg::ValueW-1:0]   wvalue_i,
  input  logic [dise_pkg::ElemLenW-1:0] wlen_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [dise_pkg::ValueW-1:0]   rvalue_o,
  output logic [dise_pkg::ElemLenW-1:0] rlen_o
);

  logic [dise_pkg::ValueW-1:0]   value_mem [MaxIntegers];
  logic [dise_pkg::ElemLenW-1:0] len_mem   [MaxIntegers];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      value_mem[waddr_i] <= wvalue_i;
      len_mem[waddr_i]   <= wlen_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rvalue_o <= value_mem[raddr_i];
      rlen_o   <= len_mem[raddr_i];
    end
  end

endmodule

@@ rtl/der_integer_sequence_encoder.sv @@
// der sequence-of-integers encoder: store values, then emit header and elements
// an item without last keeps busy_o high while the length unit shifts off the bytes of the value
// (the shared byte-length shift unit); a full store drops a non-last item and busy_o stays low
// a last item also passes through the header state StHdr; results follow one per cycle, header first,
// registered, so the header strobe follows the length unit through StHdr and the result register
// asynchronous active-low reset clears the stored-value count and all control state
module der_integer_sequence_encoder #(
  parameter int unsigned MaxIntegers = dise_pkg::MaxIntegersDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dise_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output dise_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(MaxIntegers + 1);
  localparam int unsigned IdxW = (MaxIntegers > 1) ? $clog2(MaxIntegers) : 1;

  dise_pkg::state_e      state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [dise_pkg::TotalW-1:0] total_q, total_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  last_q, last_d;
  logic [dise_pkg::ValueW-1:0] value_q, value_d;
  logic                  result_valid_q, result_valid_d;
  dise_pkg::result_t     result_q, result_d;

  logic                  accept;
  logic                  has_room;
  logic                  len_start;
  dise_pkg::len_status_t len_status;
  logic                  store_we;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [dise_pkg::ValueW-1:0]   rd_value;
  logic [dise_pkg::ElemLenW-1:0] rd_len;
  logic [CntW-1:0]       next_idx;
  logic                  is_final;

  assign accept   = start_i && !busy_o;
  assign has_room = (count_q < CntW'(MaxIntegers));
  assign next_idx = CntW'(idx_q) + CntW'(1);
  assign is_final = (next_idx == count_q);

  dise_len u_len (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (len_start),
    .value_i  (item_i.value),
    .status_o (len_status)
  );

  dise_store #(
    .MaxIntegers (MaxIntegers),
    .AddrW       (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (store_we),
    .waddr_i  (IdxW'(count_q)),
    .wvalue_i (value_q),
    .wlen_i   (len_status.len),
    .re_i     (rd_en),
    .raddr_i  (rd_addr),
    .rvalue_o (rd_value),
    .rlen_o   (rd_len)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dise_pkg::StIdle: begin
        if (accept) begin
          if (has_room) begin
            state_d = dise_pkg::StLen;
          end else if (item_i.last) begin
            state_d = dise_pkg::StHdr;
          end
        end
      end
      dise_pkg::StLen: begin
        if (len_status.done) begin
          state_d = last_q ? dise_pkg::StHdr : dise_pkg::StIdle;
        end
      end
      dise_pkg::StHdr: begin
        state_d = dise_pkg::StEmit;
      end
      dise_pkg::StEmit: begin
        if (is_final) begin
          state_d = dise_pkg::StIdle;
        end
      end
      default: begin
        state_d = dise_pkg::StIdle;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy_o         = 1'b1;
    len_start      = 1'b0;
    store_we       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    count_d        = count_q;
    total_d        = total_q;
    idx_d          = idx_q;
    last_d         = last_q;
    value_d        = value_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    unique case (state_q)
      dise_pkg::StIdle: begin
        busy_o = 1'b0;
        if (accept) begin
          last_d    = item_i.last;
          value_d   = item_i.value;
          len_start = has_room;
        end
      end
      dise_pkg::StLen: begin
        if (len_status.done) begin
          store_we = 1'b1;
          count_d  = count_q + CntW'(1);
          total_d  = total_q + dise_pkg::TotalW'(2)
                     + dise_pkg::TotalW'(len_status.len);
        end
      end
      dise_pkg::StHdr: begin
        rd_en              = 1'b1;
        rd_addr            = '0;
        idx_d              = '0;
        result_valid_d     = 1'b1;
        result_d.tag       = dise_pkg::TagSequence;
        result_d.length    = total_q;
        result_d.content   = '0;
        result_d.final_res = 1'b0;
      end
      dise_pkg::StEmit: begin
        // prefetch the following entry while this one goes out
        rd_en              = !is_final;
        rd_addr            = IdxW'(next_idx);
        idx_d              = IdxW'(next_idx);
        result_valid_d     = 1'b1;
        result_d.tag       = dise_pkg::TagInteger;
        result_d.length    = dise_pkg::TotalW'(rd_len);
        result_d.content   = rd_value;
        result_d.final_res = is_final;
        if (is_final) begin
          count_d = '0;
          total_d = '0;
        end
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= dise_pkg::StIdle;
      count_q        <= '0;
      total_q        <= '0;
      idx_q          <= '0;
      last_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      total_q        <= total_d;
      idx_q          <= idx_d;
      last_q         <= last_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

@@ rtl/dise_checker.sv @@
// port-level checker for the der integer sequence encoder, with its bind
module dise_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              result_valid_o,
  input dise_pkg::result_t result_o
);

  // every beat is a header or an integer element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.tag == dise_pkg::TagSequence ||
                        result_o.tag == dise_pkg::TagInteger))
    else $error("result beat with unknown tag");

  // header carries no content and never closes a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.tag == dise_pkg::TagSequence)
      |-> (!result_o.final_res && result_o.content == '0))
    else $error("malformed header beat");

  // element lengths stay within one to nine bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.tag == dise_pkg::TagInteger)
      |-> (result_o.length >= 7'd1 && result_o.length <= 7'd9))
    else $error("element length out of range");

  // a burst runs without gaps up to its final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.final_res) |=> result_valid_o)
    else $error("gap inside result burst");

  // nothing follows the final beat directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.final_res) |=> !result_valid_o)
    else $error("beat right after final element");

endmodule

bind der_integer_sequence_encoder dise_checker u_dise_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
